>>> rtl/rpw_pkg.sv
// Shared types, constants and tables for the ray pixel weight walker.
// Holds the trig table built at elaboration, word structs and control codes.
// No dependencies.
package rpw_pkg;

  localparam int IMG_SIZE   = 32;
  localparam int IMG_LOG2   = $clog2(IMG_SIZE);
  localparam int NUM_ANGLES = 64;
  localparam int ANG_W      = $clog2(NUM_ANGLES);
  localparam int NUM_RAYS   = 48;
  localparam int MAX_RES    = 64;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam int FRAC       = 14;
  localparam int ONE        = 1 << FRAC;
  localparam int DIV_W      = 42;
  localparam int SQRT_W     = 30;
  localparam int SQRT_RW    = SQRT_W / 2;
  localparam logic [5:0] CENTER_RST = 6'(NUM_RAYS / 2);

  localparam longint unsigned PI_Q28  = 64'd843314857;
  localparam longint unsigned ONE_Q28 = 64'd268435456;

  // Series divisors as rounded-up reciprocals; exact for terms below 2^28
  localparam int RCP_SH = 36;
  localparam longint unsigned RCP_ONE = 64'd1 << RCP_SH;
  localparam longint unsigned SIN_RCP [5] = '{
    (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd71) / 64'd72,
    (RCP_ONE + 64'd41) / 64'd42, (RCP_ONE + 64'd19) / 64'd20,
    (RCP_ONE + 64'd5) / 64'd6
  };
  localparam longint unsigned COS_RCP [6] = '{
    (RCP_ONE + 64'd131) / 64'd132, (RCP_ONE + 64'd89) / 64'd90,
    (RCP_ONE + 64'd55) / 64'd56, (RCP_ONE + 64'd29) / 64'd30,
    (RCP_ONE + 64'd11) / 64'd12, (RCP_ONE + 64'd1) / 64'd2
  };

  // Input and result words
  typedef struct packed {
    logic [5:0] angle_index;
    logic [5:0] ray_index;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  pixel_index;
    logic [15:0] pixel_weight;
    logic        hit;
    logic        last;
  } out_word_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TDIV_GO, OP_T_TAKE, OP_TSQ, OP_SQRT_GO, OP_SEC_TAKE,
    OP_PXT, OP_CC, OP_ROW_ENTRY, OP_XDIV_GO, OP_XE_TAKE, OP_FPMUL, OP_FPYC,
    OP_RDIV_GO, OP_R_TAKE, OP_R_ONE, OP_R_ZERO, OP_MUL_A, OP_EMIT_A,
    OP_MUL_B, OP_EMIT_B, OP_EMIT_F, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TDIV, ST_TDIV_W, ST_TSQ, ST_SQRT, ST_SQRT_W, ST_PXT, ST_CC,
    ST_ENTRY, ST_XDIV_W, ST_FPMUL, ST_FPYC, ST_STEP, ST_RDIV_W, ST_MUL_A,
    ST_EMIT_A, ST_CHK_B, ST_MUL_B, ST_EMIT_B, ST_EMIT_F, ST_FINISH
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic cc_ge_grid;
    logic cc_neg;
    logic t_zero;
    logic xe_ge_grid;
    logic yc_neg;
    logic yc_ge_t;
    logic iy_last;
    logic iy_full;
    logic ix_last;
    logic n_max;
    logic out_free;
    logic div_busy;
    logic sqrt_busy;
  } dp_stat_t;

  // Trig table, evaluated at elaboration
  function automatic longint unsigned mul_q28(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 27)) >> 28;
  endfunction

  function automatic longint unsigned q28_to_q14(longint unsigned v);
    return (v + (64'd1 << 13)) >> 14;
  endfunction

  // returns {sin, cos} of r*pi/65536 for r in 0..16384, Q14
  function automatic logic [31:0] octant_trig(longint unsigned r);
    longint unsigned x, x2, u, sm, cm;
    x  = (r * PI_Q28 + 64'd32768) >> 16;
    x2 = mul_q28(x, x);
    u  = ONE_Q28;
    for (int k = 0; k < 5; k++) u = ONE_Q28 - ((mul_q28(x2, u) * SIN_RCP[k]) >> RCP_SH);
    sm = q28_to_q14(mul_q28(x, u));
    u  = ONE_Q28;
    for (int k = 0; k < 6; k++) u = ONE_Q28 - ((mul_q28(x2, u) * COS_RCP[k]) >> RCP_SH);
    cm = q28_to_q14(u);
    return {sm[15:0], cm[15:0]};
  endfunction

  // returns {sin, cos} as signed Q1.14
  function automatic logic [31:0] trig_entry(int idx);
    longint unsigned ph, r;
    logic [31:0] sc;
    logic signed [15:0] a, b, s, c;
    int quad;
    ph   = (longint'(idx) << (16 - ANG_W)) & 64'h1FFFF;
    quad = int'((ph >> 15) & 64'd3);
    r    = ph & 64'd32767;
    if (r <= 64'd16384) begin
      sc = octant_trig(r);
      a  = signed'(sc[31:16]);
      b  = signed'(sc[15:0]);
    end else begin
      sc = octant_trig(64'd32768 - r);
      a  = signed'(sc[15:0]);
      b  = signed'(sc[31:16]);
    end
    case (quad)
      0:       begin s = a;  c = b;  end
      1:       begin s = b;  c = -a; end
      2:       begin s = -a; c = -b; end
      default: begin s = -b; c = a;  end
    endcase
    return {s, c};
  endfunction

  typedef logic [31:0] trig_tab_t [NUM_ANGLES];

  function automatic trig_tab_t build_trig();
    trig_tab_t tab;
    for (int i = 0; i < NUM_ANGLES; i++) tab[i] = trig_entry(i);
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig();

  // Folded (column,row) to linear image address
  function automatic logic [9:0] map_addr(logic [IMG_LOG2-1:0] col,
                                          logic [IMG_LOG2-1:0] row,
                                          logic flip, logic swap);
    logic [IMG_LOG2-1:0] r, c;
    if (swap) begin
      r = col;
      c = flip ? (IMG_LOG2'(IMG_SIZE - 1) - row) : row;
    end else begin
      r = row;
      c = flip ? (IMG_LOG2'(IMG_SIZE - 1) - col) : col;
    end
    return 10'({r, c});
  endfunction

endpackage

>>> rtl/rpw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rpw_pkg for the dividend width.
module rpw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpw_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      busy,
  output logic [rpw_pkg::DIV_W-1:0] quotient
);

  localparam int CW = $clog2(rpw_pkg::DIV_W + 1);

  logic [rpw_pkg::DIV_W-1:0] quo_r;
  logic [15:0]               rem_r, dvs_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r;
  logic [16:0]               shifted, diff;
  logic                      ge;

  // trial subtract of the next bit
  always_comb begin
    shifted = {rem_r, quo_r[rpw_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(rpw_pkg::DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[15:0] : shifted[15:0];
      quo_r <= {quo_r[rpw_pkg::DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> rtl/rpw_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rpw_pkg for the operand width.
module rpw_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rpw_pkg::SQRT_W-1:0]  radicand,
  output logic                        busy,
  output logic [rpw_pkg::SQRT_RW-1:0] root
);

  localparam int RW = rpw_pkg::SQRT_RW;
  localparam int CW = $clog2(RW + 1);

  logic [rpw_pkg::SQRT_W-1:0] val_r;
  logic [RW+1:0]              rem_r;
  logic [RW-1:0]              root_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r;
  logic [RW+3:0]              shifted, trial, diff;
  logic                       ge;

  // bring down two bits, test root*4+1
  always_comb begin
    shifted = {rem_r, val_r[rpw_pkg::SQRT_W-1 -: 2]};
    trial   = (RW+4)'({root_r, 2'b01});
    diff    = shifted - trial;
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(RW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
      root_r <= {root_r[RW-2:0], ge};
      val_r  <= {val_r[rpw_pkg::SQRT_W-3:0], 2'b00};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

>>> rtl/rpw_datapath.sv
// Ray setup and pixel walk datapath: fold, slope, secant, entry, weights.
// Depends on rpw_pkg, rpw_div and rpw_sqrt.
module rpw_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rpw_pkg::dp_cmd_t   cmd,
  input  rpw_pkg::in_word_t  in_data,
  input  logic [5:0]         ray_center,
  input  logic               out_ready,
  output rpw_pkg::dp_stat_t  stat,
  output logic               out_valid,
  output rpw_pkg::out_word_t out_data
);

  localparam int L = rpw_pkg::IMG_LOG2;

  // ray state
  logic signed [25:0] px_r, py_r;
  logic [14:0]        minor_r, major_r, t_r, sec_r, fp_r, r_r;
  logic               flip_r, swap_r;
  logic [29:0]        tt_r;
  logic signed [41:0] prod_r;
  logic signed [27:0] cc_r;
  logic [L:0]         ix_r, iy_r;
  logic signed [19:0] yc_r;
  logic [rpw_pkg::CNT_W-1:0] n_r;
  rpw_pkg::out_word_t pend_r, out_r;
  logic               pend_v_r, out_v_r;

  // divider, shared by the slope, entry and ratio divides, and square-root unit
  logic                      div_start, div_busy, sqrt_busy;
  logic [rpw_pkg::DIV_W-1:0] div_dend, quo;
  logic [15:0]               div_dsr;
  logic [14:0]               sq_root;

  rpw_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dend), .divisor(div_dsr),
    .busy(div_busy), .quotient(quo)
  );

  rpw_sqrt u_sqrt (
    .clk, .rst_n, .start(cmd.op == rpw_pkg::OP_SQRT_GO),
    .radicand(30'(rpw_pkg::ONE_Q28) + tt_r), .busy(sqrt_busy), .root(sq_root)
  );

  // fold of the ray at load
  logic [31:0]        trig;
  logic signed [15:0] s0, c0, s1, c1, c2, mn, mj;
  logic signed [6:0]  ind;
  logic signed [24:0] px0, py0, px1, px2, py2;
  logic               neg1, flp, swp;

  always_comb begin
    trig = rpw_pkg::TRIG_TAB[in_data.angle_index];
    s0   = signed'(trig[31:16]);
    c0   = signed'(trig[15:0]);
    ind  = signed'(7'({1'b0, in_data.ray_index}) - 7'({1'b0, ray_center}));
    px0  = -(25'(s0) * 25'(ind));
    py0  = 25'(c0) * 25'(ind);
    neg1 = (s0 < 0) || (s0 == 0 && c0 < 0);
    s1   = neg1 ? -s0 : s0;
    c1   = neg1 ? -c0 : c0;
    flp  = c1 < 0;
    c2   = flp ? -c1 : c1;
    px1  = flp ? -px0 : px0;
    swp  = s1 > c2;
    mn   = swp ? c2 : s1;
    mj   = swp ? s1 : c2;
    px2  = swp ? py0 : px1;
    py2  = swp ? px1 : py0;
  end

  // divider operand select
  logic [27:0] ncc;
  always_comb begin
    ncc       = 28'(-cc_r);
    div_start = 1'b0;
    div_dend  = '0;
    div_dsr   = {1'b0, t_r};
    case (cmd.op)
      rpw_pkg::OP_TDIV_GO: begin
        div_start = 1'b1;
        div_dend  = rpw_pkg::DIV_W'({minor_r, 14'd0});
        div_dsr   = {1'b0, major_r};
      end
      rpw_pkg::OP_XDIV_GO: begin
        div_start = 1'b1;
        div_dend  = {ncc, 14'd0};
      end
      rpw_pkg::OP_RDIV_GO: begin
        div_start = 1'b1;
        div_dend  = rpw_pkg::DIV_W'({yc_r[14:0], 14'd0});
      end
      default: ;
    endcase
  end

  // rounded, saturated weight from the product register, or the secant for a full step
  logic [16:0] w_round;
  logic [15:0] w_sat;
  rpw_pkg::out_word_t new_w;
  logic        emit;
  always_comb begin
    w_round = 17'((prod_r[30:0] + 31'd8192) >> rpw_pkg::FRAC);
    w_sat   = w_round[16] ? 16'hFFFF : w_round[15:0];
    new_w.pixel_index  = rpw_pkg::map_addr(ix_r[L-1:0], iy_r[L-1:0], flip_r, swap_r);
    new_w.pixel_weight = (cmd.op == rpw_pkg::OP_EMIT_F) ? 16'(sec_r) : w_sat;
    new_w.hit          = 1'b1;
    new_w.last         = 1'b0;
    emit = (cmd.op == rpw_pkg::OP_EMIT_A) || (cmd.op == rpw_pkg::OP_EMIT_B) ||
           (cmd.op == rpw_pkg::OP_EMIT_F);
  end

  // ray registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rpw_pkg::OP_LOAD: begin
        px_r    <= 26'(px2) + 26'sd8192 * 26'(rpw_pkg::IMG_SIZE);
        py_r    <= 26'(py2) + 26'sd8192 * 26'(rpw_pkg::IMG_SIZE);
        minor_r <= mn[14:0];
        major_r <= (mj == 0) ? 15'd1 : mj[14:0];
        flip_r  <= flp;
        swap_r  <= swp;
      end
      rpw_pkg::OP_T_TAKE:   t_r    <= quo[14:0];
      rpw_pkg::OP_TSQ:      tt_r   <= 30'(t_r * t_r);
      rpw_pkg::OP_SEC_TAKE: sec_r  <= sq_root;
      rpw_pkg::OP_PXT:
        prod_r <= $signed({{16{px_r[25]}}, px_r}) * $signed({27'd0, t_r});
      rpw_pkg::OP_CC:       cc_r   <= 28'(py_r) - 28'(prod_r >>> rpw_pkg::FRAC);
      rpw_pkg::OP_ROW_ENTRY: begin
        ix_r <= '0;
        iy_r <= {1'b0, cc_r[L+rpw_pkg::FRAC-1:rpw_pkg::FRAC]};
        yc_r <= signed'(20'(t_r)) + signed'(20'(cc_r[13:0])) - 20'sd16384;
      end
      rpw_pkg::OP_XE_TAKE: begin
        ix_r <= {1'b0, quo[L+rpw_pkg::FRAC-1:rpw_pkg::FRAC]};
        iy_r <= '0;
        fp_r <= 15'(rpw_pkg::ONE) - {1'b0, quo[13:0]};
      end
      rpw_pkg::OP_FPMUL:    prod_r <= signed'({12'd0, 30'(fp_r * t_r)});
      rpw_pkg::OP_FPYC:
        yc_r <= signed'(20'(({1'b0, prod_r[29:0]} + 31'd8192) >> rpw_pkg::FRAC))
                - 20'sd16384;
      rpw_pkg::OP_R_TAKE:   r_r    <= quo[14:0];
      rpw_pkg::OP_R_ONE:    r_r    <= 15'(rpw_pkg::ONE);
      rpw_pkg::OP_R_ZERO:   r_r    <= '0;
      rpw_pkg::OP_MUL_A:
        prod_r <= signed'({11'd0, 31'(sec_r * (15'(rpw_pkg::ONE) - r_r))});
      rpw_pkg::OP_MUL_B:    prod_r <= signed'({11'd0, 31'(sec_r * r_r)});
      rpw_pkg::OP_EMIT_A:   iy_r   <= iy_r + 1'b1;
      rpw_pkg::OP_EMIT_B: begin
        ix_r <= ix_r + 1'b1;
        yc_r <= yc_r + signed'(20'(t_r)) - 20'sd16384;
      end
      rpw_pkg::OP_EMIT_F: begin
        ix_r <= ix_r + 1'b1;
        yc_r <= yc_r + signed'(20'(t_r));
      end
      default: ;
    endcase
  end

  // result count, pending word and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.op == rpw_pkg::OP_LOAD) begin
        n_r      <= '0;
        pend_v_r <= 1'b0;
      end
      if (emit) begin
        n_r      <= n_r + 1'b1;
        pend_v_r <= 1'b1;
      end
      if (cmd.op == rpw_pkg::OP_FINISH) pend_v_r <= 1'b0;
      if ((emit && pend_v_r) || cmd.op == rpw_pkg::OP_FINISH) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend_r <= new_w;
      if (pend_v_r) out_r <= pend_r;
    end else if (cmd.op == rpw_pkg::OP_FINISH) begin
      if (pend_v_r) out_r <= '{pixel_index: pend_r.pixel_index,
                               pixel_weight: pend_r.pixel_weight,
                               hit: 1'b1, last: 1'b1};
      else          out_r <= '{pixel_index: '0, pixel_weight: '0,
                               hit: 1'b0, last: 1'b1};
    end
  end

  // status to the controller
  always_comb begin
    stat.cc_ge_grid = cc_r >= 28'sd16384 * 28'(rpw_pkg::IMG_SIZE);
    stat.cc_neg     = cc_r[27];
    stat.t_zero     = t_r == '0;
    stat.xe_ge_grid = |quo[rpw_pkg::DIV_W-1:L+rpw_pkg::FRAC];
    stat.yc_neg     = yc_r[19];
    stat.yc_ge_t    = yc_r >= signed'(20'(t_r));
    stat.iy_last    = iy_r >= (L+1)'(rpw_pkg::IMG_SIZE - 1);
    stat.iy_full    = iy_r >= (L+1)'(rpw_pkg::IMG_SIZE);
    stat.ix_last    = ix_r >= (L+1)'(rpw_pkg::IMG_SIZE - 1);
    stat.n_max      = n_r == rpw_pkg::CNT_W'(rpw_pkg::MAX_RES);
    stat.out_free   = !out_v_r || out_ready;
    stat.div_busy   = div_busy;
    stat.sqrt_busy  = sqrt_busy;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/rpw_ctrl.sv
// Sequencer for ray setup and the pixel walk.
// Depends on rpw_pkg; drives rpw_datapath through dp_cmd_t.
module rpw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rpw_pkg::dp_stat_t stat,
  output logic              in_ready,
  output rpw_pkg::dp_cmd_t  cmd
);

  rpw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rpw_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = rpw_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      rpw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = rpw_pkg::OP_LOAD;
          state_nxt = rpw_pkg::ST_TDIV;
        end
      end
      rpw_pkg::ST_TDIV: begin
        cmd.op    = rpw_pkg::OP_TDIV_GO;
        state_nxt = rpw_pkg::ST_TDIV_W;
      end
      rpw_pkg::ST_TDIV_W: if (!stat.div_busy) begin
        cmd.op    = rpw_pkg::OP_T_TAKE;
        state_nxt = rpw_pkg::ST_TSQ;
      end
      rpw_pkg::ST_TSQ: begin
        cmd.op    = rpw_pkg::OP_TSQ;
        state_nxt = rpw_pkg::ST_SQRT;
      end
      rpw_pkg::ST_SQRT: begin
        cmd.op    = rpw_pkg::OP_SQRT_GO;
        state_nxt = rpw_pkg::ST_SQRT_W;
      end
      rpw_pkg::ST_SQRT_W: if (!stat.sqrt_busy) begin
        cmd.op    = rpw_pkg::OP_SEC_TAKE;
        state_nxt = rpw_pkg::ST_PXT;
      end
      rpw_pkg::ST_PXT: begin
        cmd.op    = rpw_pkg::OP_PXT;
        state_nxt = rpw_pkg::ST_CC;
      end
      rpw_pkg::ST_CC: begin
        cmd.op    = rpw_pkg::OP_CC;
        state_nxt = rpw_pkg::ST_ENTRY;
      end
      // entry on the left edge or the bottom edge, or a miss
      rpw_pkg::ST_ENTRY: begin
        if (stat.cc_ge_grid) state_nxt = rpw_pkg::ST_FINISH;
        else if (stat.cc_neg) begin
          if (stat.t_zero) state_nxt = rpw_pkg::ST_FINISH;
          else begin
            cmd.op    = rpw_pkg::OP_XDIV_GO;
            state_nxt = rpw_pkg::ST_XDIV_W;
          end
        end else begin
          cmd.op    = rpw_pkg::OP_ROW_ENTRY;
          state_nxt = rpw_pkg::ST_STEP;
        end
      end
      rpw_pkg::ST_XDIV_W: if (!stat.div_busy) begin
        if (stat.xe_ge_grid) state_nxt = rpw_pkg::ST_FINISH;
        else begin
          cmd.op    = rpw_pkg::OP_XE_TAKE;
          state_nxt = rpw_pkg::ST_FPMUL;
        end
      end
      rpw_pkg::ST_FPMUL: begin
        cmd.op    = rpw_pkg::OP_FPMUL;
        state_nxt = rpw_pkg::ST_FPYC;
      end
      rpw_pkg::ST_FPYC: begin
        cmd.op    = rpw_pkg::OP_FPYC;
        state_nxt = rpw_pkg::ST_STEP;
      end
      // one walk step: split over two pixels or full secant
      rpw_pkg::ST_STEP: begin
        if (stat.n_max) state_nxt = rpw_pkg::ST_FINISH;
        else if (!stat.yc_neg) begin
          if (stat.iy_last) state_nxt = rpw_pkg::ST_FINISH;
          else if (stat.t_zero) begin
            cmd.op    = rpw_pkg::OP_R_ZERO;
            state_nxt = rpw_pkg::ST_MUL_A;
          end else if (stat.yc_ge_t) begin
            cmd.op    = rpw_pkg::OP_R_ONE;
            state_nxt = rpw_pkg::ST_MUL_A;
          end else begin
            cmd.op    = rpw_pkg::OP_RDIV_GO;
            state_nxt = rpw_pkg::ST_RDIV_W;
          end
        end else begin
          if (stat.iy_full || stat.ix_last) state_nxt = rpw_pkg::ST_FINISH;
          else state_nxt = rpw_pkg::ST_EMIT_F;
        end
      end
      rpw_pkg::ST_RDIV_W: if (!stat.div_busy) begin
        cmd.op    = rpw_pkg::OP_R_TAKE;
        state_nxt = rpw_pkg::ST_MUL_A;
      end
      rpw_pkg::ST_MUL_A: begin
        cmd.op    = rpw_pkg::OP_MUL_A;
        state_nxt = rpw_pkg::ST_EMIT_A;
      end
      rpw_pkg::ST_EMIT_A: if (stat.out_free) begin
        cmd.op    = rpw_pkg::OP_EMIT_A;
        state_nxt = rpw_pkg::ST_CHK_B;
      end
      rpw_pkg::ST_CHK_B: begin
        if (stat.ix_last || stat.n_max) state_nxt = rpw_pkg::ST_FINISH;
        else state_nxt = rpw_pkg::ST_MUL_B;
      end
      rpw_pkg::ST_MUL_B: begin
        cmd.op    = rpw_pkg::OP_MUL_B;
        state_nxt = rpw_pkg::ST_EMIT_B;
      end
      rpw_pkg::ST_EMIT_B: if (stat.out_free) begin
        cmd.op    = rpw_pkg::OP_EMIT_B;
        state_nxt = rpw_pkg::ST_STEP;
      end
      rpw_pkg::ST_EMIT_F: if (stat.out_free) begin
        cmd.op    = rpw_pkg::OP_EMIT_F;
        state_nxt = rpw_pkg::ST_STEP;
      end
      rpw_pkg::ST_FINISH: if (stat.out_free) begin
        cmd.op    = rpw_pkg::OP_FINISH;
        state_nxt = rpw_pkg::ST_IDLE;
      end
      default: state_nxt = rpw_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/ray_pixel_weight_walker.sv
// Ray pixel weight walker: one ray word in, a run of pixel words out; one ray at a time.
// Setup runs a slope divide and then a secant square root before the first walk step;
// a bottom-edge entry adds its own divide.
// Walk: full steps give one pixel each, split steps a pixel pair after a ratio divide
// (skipped when the split ratio is 0 or 1); output stalls hold both. Words leave one emit late.
// Reset clears the sequencer and output valid and sets ray_center to 24.
module ray_pixel_weight_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpw_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [5:0]        center_r;
  rpw_pkg::dp_cmd_t  cmd;
  rpw_pkg::dp_stat_t stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) center_r <= rpw_pkg::CENTER_RST;
    else if (psel && penable && pwrite && paddr[2] == 1'b0) center_r <= pwdata[5:0];
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {26'd0, center_r} : 32'd0;

  rpw_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .stat, .in_ready, .cmd
  );

  rpw_datapath u_dp (
    .clk, .rst_n, .cmd, .in_data, .ray_center(center_r), .out_ready,
    .stat, .out_valid, .out_data
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a ray is in progress");

  a_miss_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.last && out_data.pixel_weight == 16'd0 && out_data.pixel_index == 10'd0))
    else $error("miss word malformed");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[2] == 1'b0) |=> center_r == $past(pwdata[5:0]))
    else $error("ray_center write lost");
`endif

endmodule

>>> verif/tb.sv
// Testbench for the ray pixel weight walker: random and directed rays,
// per-pixel words checked against an in-bench fixed-point walk model.
// Depends on rpw_pkg for the word types and the image constants.
module tb;

  localparam logic [2:0] REG_RAY_CENTER = 3'd0;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  rpw_pkg::in_word_t in_data;
  rpw_pkg::out_word_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  ray_pixel_weight_walker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rpw_pkg::out_word_t pixel_q[$];
  logic [5:0] center_q;
  int mismatches = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

  // Q28 rounded product
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 27)) >> 28;
  endfunction

  // sin/cos of r*pi/65536 over the first octant, Q14
  function automatic void oct_sc(longint unsigned r, output longint sn, output longint cs);
    longint unsigned x, x2, u;
    longint unsigned sd[5];
    longint unsigned cd[6];
    sd = '{110, 72, 42, 20, 6};
    cd = '{132, 90, 56, 30, 12, 2};
    x = (r * 64'd843314857 + 64'd32768) >> 16;
    x2 = qmul(x, x);
    u = 64'd268435456;
    for (int k = 0; k < 5; k++) u = 64'd268435456 - qmul(x2, u) / sd[k];
    sn = longint'((qmul(x, u) + 8192) >> 14);
    u = 64'd268435456;
    for (int k = 0; k < 6; k++) u = 64'd268435456 - qmul(x2, u) / cd[k];
    cs = longint'((u + 8192) >> 14);
  endfunction

  function automatic longint fdiv_sh(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v + (longint'(1) << k) - 1) >>> k);
  endfunction

  function automatic longint isq(longint unsigned v);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin v -= res + b; res = (res >> 1) + b; end
      else res >>= 1;
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [9:0] pix_addr(longint col, longint row, bit flip, bit swp);
    longint r, c;
    if (swp) begin
      r = col; c = flip ? (rpw_pkg::IMG_SIZE - 1 - row) : row;
    end else begin
      r = row; c = flip ? (rpw_pkg::IMG_SIZE - 1 - col) : col;
    end
    return 10'(r * rpw_pkg::IMG_SIZE + c);
  endfunction

  function automatic void push_pix(logic [9:0] a, longint w);
    rpw_pkg::out_word_t o;
    o.pixel_index = a;
    o.pixel_weight = (w > 65535) ? 16'hFFFF : 16'(w);
    o.hit = 1; o.last = 0;
    pixel_q.push_back(o);
  endfunction

  // Walk one ray and queue its pixel words
  function automatic void walk_ray(rpw_pkg::in_word_t w);
    longint ph, quad, r, a, b, s, c, ind, px, py, tmp, mn, mj, t, sec, cc;
    longint ix, iy, yc, xe, fp, rr, grid, n0;
    bit flip, swp, miss;
    rpw_pkg::out_word_t o;
    ix = 0; iy = 0; yc = 0; flip = 0; swp = 0; miss = 0;
    grid = longint'(rpw_pkg::IMG_SIZE) << 14;
    n0 = pixel_q.size();
    ph = ((longint'(w.angle_index) << 16) / rpw_pkg::NUM_ANGLES) & 'h1FFFF;
    quad = (ph >> 15) & 3; r = ph & 32767;
    if (r <= 16384) oct_sc(r, a, b);
    else oct_sc(32768 - r, b, a);
    case (quad)
      0: begin s = a; c = b; end
      1: begin s = b; c = -a; end
      2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
    ind = longint'(w.ray_index) - longint'(center_q);
    px = -s * ind; py = c * ind;
    if (s < 0 || (s == 0 && c < 0)) begin s = -s; c = -c; end
    if (c < 0) begin flip = 1; c = -c; px = -px; end
    if (s > c) begin swp = 1; tmp = px; px = py; py = tmp; mn = c; mj = s; end
    else begin mn = s; mj = c; end
    if (mj <= 0) mj = 1;
    t = (mn << 14) / mj;
    sec = isq(64'd268435456 + longint'(t * t));
    px += rpw_pkg::IMG_SIZE * 8192; py += rpw_pkg::IMG_SIZE * 8192;
    cc = py - fdiv_sh(px * t, 14);
    if (cc >= grid) miss = 1;
    else if (cc < 0) begin
      if (t == 0) miss = 1;
      else begin
        xe = ((-cc) << 14) / t;
        if (xe >= grid) miss = 1;
        else begin
          ix = xe >>> 14; iy = 0;
          fp = ((ix + 1) << 14) - xe;
          yc = ((fp * t + 8192) >>> 14) - 16384;
        end
      end
    end else begin
      iy = cc >>> 14;
      yc = t - (((iy + 1) << 14) - cc);
    end
    while (!miss && pixel_q.size() - n0 < rpw_pkg::MAX_RES) begin
      if (yc >= 0) begin
        if (iy + 1 >= rpw_pkg::IMG_SIZE) break;
        rr = (t > 0) ? (yc << 14) / t : 0;
        if (rr > 16384) rr = 16384;
        push_pix(pix_addr(ix, iy, flip, swp), (sec * (16384 - rr) + 8192) >>> 14);
        iy++;
        if (ix + 1 >= rpw_pkg::IMG_SIZE || pixel_q.size() - n0 >= rpw_pkg::MAX_RES) break;
        push_pix(pix_addr(ix, iy, flip, swp), (sec * rr + 8192) >>> 14);
        ix++; yc += t - 16384;
      end else begin
        if (iy >= rpw_pkg::IMG_SIZE || ix + 1 >= rpw_pkg::IMG_SIZE) break;
        push_pix(pix_addr(ix, iy, flip, swp), sec);
        ix++; yc += t;
      end
    end
    if (pixel_q.size() == n0) begin
      o = '0; o.last = 1;
      pixel_q.push_back(o);
    end else pixel_q[pixel_q.size() - 1].last = 1;
  endfunction

  // Send one ray word after a random gap; valid stays up until the next gap or drain
  task automatic send_ray(logic [5:0] ang, logic [5:0] ray);
    rpw_pkg::in_word_t w;
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    w.angle_index = ang; w.ray_index = ray;
    in_data <= w; in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_ray(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_center(logic [5:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_RAY_CENTER;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    center_q = v;
  endtask

  // Result checker with random stalls
  initial begin
    int stall;
    rpw_pkg::out_word_t e;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        e = pixel_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch idx %0d/%0d wgt %0d/%0d hit %b/%b last %b/%b (exp/act)",
                     e.pixel_index, out_data.pixel_index, e.pixel_weight,
                     out_data.pixel_weight, e.hit, out_data.hit, e.last, out_data.last);
        end
      end
    end
  end

  task automatic test_axis_and_extremes();
    logic [5:0] angs[8];
    angs = '{0, 16, 32, 48, 63, 8, 24, 40};
    foreach (angs[i]) begin
      send_ray(angs[i], 6'd24);
      send_ray(angs[i], 6'd0);
      send_ray(angs[i], 6'd47);
    end
    send_ray(6'd63, 6'd63);
  endtask

  task automatic test_center_settings();
    logic [5:0] cs[4];
    cs = '{0, 47, 63, 10};
    foreach (cs[i]) begin
      drain();
      write_center(cs[i]);
      repeat (15) send_ray(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
    drain();
    write_center(6'd24);
  endtask

  task automatic test_random_rays();
    for (int i = 0; i < 145; i++) begin
      if (i == 80) drain();
      if ($urandom_range(0, 9) == 0)
        send_ray(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      else
        send_ray(6'($urandom_range(0, 63)), 6'($urandom_range(0, 47)));
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    center_q = 6'd24;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_axis_and_extremes();
    test_center_settings();
    test_random_rays();
    drain();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> ray_pixel_weight_walker.f
rtl/rpw_pkg.sv
rtl/rpw_div.sv
rtl/rpw_sqrt.sv
rtl/rpw_datapath.sv
rtl/rpw_ctrl.sv
rtl/ray_pixel_weight_walker.sv
verif/tb.sv
